// ===== rtl/complex_add_rect_to_polar_core_defines.svh =====
// Assertion macros used by the port-level checker file.
`ifndef COMPLEX_ADD_RECT_TO_POLAR_CORE_DEFINES_SVH
`define COMPLEX_ADD_RECT_TO_POLAR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CARP_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CARP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/carp_pkg.sv =====
// Shared constants, types and tables of the complex add and polar conversion core.
`default_nettype none
package carp_pkg;

	localparam int DATA_WIDTH    = 16;
	localparam int FRAC_BITS     = 8;
	localparam int CORDIC_STAGES = 16;
	localparam int GUARD_BITS    = 12;
	localparam int ANG_FRAC      = 16;

	localparam int SUM_W    = DATA_WIDTH + 1;
	localparam int FIRST_W  = 18;
	localparam int SECOND_W = 17;
	localparam int OPND_W   = SUM_W + 1;
	localparam int XW       = 32;
	localparam int ZW       = 26;
	localparam int IN_W     = 4 * DATA_WIDTH;
	localparam int OUT_W    = ((FIRST_W + SECOND_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam longint GAIN_Q32 = 64'd2608131496;
	localparam int GAIN_HI      = int'(GAIN_Q32 >> 16);
	localparam int GAIN_LO      = int'(GAIN_Q32 & 64'hFFFF);
	localparam int PROD_W       = XW - 1 + 16;
	localparam int MAG_SH       = GUARD_BITS + 16;
	localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;

	localparam logic signed [ZW-1:0] DEG90_Q16 = ZW'(90 <<< ANG_FRAC);
	localparam logic signed [OPND_W-1:0] DEG90_Q8 = OPND_W'(90 <<< FRAC_BITS);
	localparam logic signed [OPND_W-1:0] DEG180_Q8 = OPND_W'(180 <<< FRAC_BITS);

	typedef struct packed {
		logic                     polar;
		logic                     vec;
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
		logic signed [ZW-1:0]     z;
	} carp_item_t;

	typedef struct packed {
		logic       valid;
		carp_item_t item;
	} carp_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} carp_qstat_t;

	// atan(2^-i) in degrees, Q16, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_deg_q16(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:       v = ZW'(2949120);
			1:       v = ZW'(1740967);
			2:       v = ZW'(919879);
			3:       v = ZW'(466945);
			4:       v = ZW'(234379);
			5:       v = ZW'(117304);
			6:       v = ZW'(58666);
			7:       v = ZW'(29335);
			8:       v = ZW'(14668);
			9:       v = ZW'(7334);
			10:      v = ZW'(3667);
			11:      v = ZW'(1833);
			12:      v = ZW'(917);
			13:      v = ZW'(458);
			14:      v = ZW'(229);
			15:      v = ZW'(115);
			16:      v = ZW'(57);
			17:      v = ZW'(29);
			18:      v = ZW'(14);
			19:      v = ZW'(7);
			20:      v = ZW'(4);
			21:      v = ZW'(2);
			22:      v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/complex_add_rect_to_polar_core.sv =====
// Top level of the complex add core with rectangular or polar result.
// Each input transaction carries two complex numbers in signed Q8.8; the core
// adds them and returns one result transaction: the real and imaginary sums,
// or, when polar_output is set (the reset value), the magnitude and the angle
// in degrees (Q9.8, -180 to 180, zero at the origin) from a 16-stage CORDIC
// vectoring pipeline with gain compensation. The mode is sampled when an
// input transaction is taken. One transaction is accepted per clock while
// the job queue has room; from input to output a transaction passes the sum
// register, the four-entry job queue, the load stage, the 16 rotation stages,
// the gain multiply stage and the output register. When the output stalls, the
// rotation pipeline holds and the queue keeps taking input until it fills.
`default_nettype none
module complex_add_rect_to_polar_core
	import carp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,     // polar_output
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_W-1:0]   s_axis_tdata,  // first_real, first_imag, second_real, second_imag
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,  // first_value, second_value, zero fill
	output logic                   m_axis_tuser   // is_polar
);

	carp_push_t  push;
	carp_qstat_t qstat;
	carp_item_t  head;
	logic        pop;

	carp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.qstat         (qstat),
		.push          (push)
	);

	carp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	carp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ===== rtl/carp_front.sv =====
// Front end: accepts operand pairs, adds them and sorts each sum into a pass or rotate job.
`default_nettype none
module carp_front
	import carp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	input  wire carp_qstat_t      qstat,
	output carp_push_t            push
);

	logic                    polar_q;
	logic                    valid_s1;
	logic                    polar_s1;
	logic signed [SUM_W-1:0] re_s1;
	logic signed [SUM_W-1:0] im_s1;

	logic signed [DATA_WIDTH-1:0] fr, fi, sr, si;
	logic signed [OPND_W-1:0] re_x, im_x, re_n, im_n;
	carp_item_t item;

	assign fr = s_axis_tdata[DATA_WIDTH-1:0];
	assign fi = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign sr = s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
	assign si = s_axis_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH];

	assign s_axis_tready = !valid_s1 || !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_q <= 1'b1;
		end else if (cfg_we) begin
			polar_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			re_s1    <= SUM_W'(fr) + SUM_W'(sr);
			im_s1    <= SUM_W'(fi) + SUM_W'(si);
			polar_s1 <= polar_q;
		end
	end

	assign re_x = OPND_W'(re_s1);
	assign im_x = OPND_W'(im_s1);
	assign re_n = -re_x;
	assign im_n = -im_x;

	always_comb begin
		item.polar = polar_s1;
		item.vec   = 1'b0;
		item.a     = re_x;
		item.b     = im_x;
		item.z     = '0;
		if (polar_s1) begin
			if (im_s1 == '0) begin
				item.a = re_s1[SUM_W-1] ? re_n : re_x;
				item.b = re_s1[SUM_W-1] ? DEG180_Q8 : '0;
			end else if (re_s1 == '0) begin
				item.a = im_s1[SUM_W-1] ? im_n : im_x;
				item.b = im_s1[SUM_W-1] ? -DEG90_Q8 : DEG90_Q8;
			end else begin
				item.vec = 1'b1;
				// left half plane: rotate by 90 degrees first
				if (re_s1[SUM_W-1]) begin
					if (!im_s1[SUM_W-1]) begin
						item.a = im_x;
						item.b = re_n;
						item.z = DEG90_Q16;
					end else begin
						item.a = im_n;
						item.b = re_x;
						item.z = -DEG90_Q16;
					end
				end
			end
		end
	end

	assign push.valid = valid_s1 && !qstat.full;
	assign push.item  = item;

endmodule
`default_nettype wire

// ===== rtl/carp_queue.sv =====
// Short job queue between the front end and the rotation pipeline.
`default_nettype none
module carp_queue
	import carp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire carp_push_t  push,
	input  wire logic        pop,
	output carp_qstat_t      qstat,
	output carp_item_t       head
);

	carp_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign qstat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push.valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/carp_back.sv =====
// Back end: CORDIC vectoring pipeline, gain multiply, rounding and output register.
`default_nettype none
module carp_back
	import carp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire carp_qstat_t       qstat,
	input  wire carp_item_t        head,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,
	output logic                   m_axis_tuser
);

	localparam int N = CORDIC_STAGES;

	logic                 en;
	logic                 v_s   [0:N];
	logic                 pol_s [0:N];
	logic                 vec_s [0:N];
	logic signed [XW-1:0] x_s   [0:N];
	logic signed [XW-1:0] y_s   [0:N];
	logic signed [ZW-1:0] z_s   [0:N];

	logic                        v_s1, pol_s1, vec_s1;
	logic [PROD_W-1:0]           hi_s1, lo_s1;
	logic signed [SECOND_W-1:0]  ang_s1;
	logic [FIRST_W-1:0]          pa_s1;
	logic [SECOND_W-1:0]         pb_s1;

	logic                  out_valid_q;
	logic [OUT_W-1:0]      data_q;
	logic                  user_q;

	logic signed [XW-1:0]  xa, xb;
	logic [XW-2:0]         ux;
	logic signed [ZW:0]    zt, zr;
	logic signed [SECOND_W-1:0] ang;
	logic [PROD_W:0]       prod, rnd;
	logic [FIRST_W-1:0]    mag;
	logic [FIRST_W-1:0]    first_v;
	logic [SECOND_W-1:0]   second_v;

	// the whole pipeline advances together; the queue absorbs a stalled output
	assign en  = !out_valid_q || m_axis_tready;
	assign pop = en && !qstat.empty;

	assign xa = XW'(head.a);
	assign xb = XW'(head.b);

	// load stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= !qstat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pol_s[0] <= head.polar;
			vec_s[0] <= head.vec;
			x_s[0]   <= head.vec ? (xa <<< GUARD_BITS) : xa;
			y_s[0]   <= head.vec ? (xb <<< GUARD_BITS) : xb;
			z_s[0]   <= head.z;
		end
	end

	// one micro-rotation per stage for vectoring jobs; pass jobs go through unchanged
	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ATAN_I = atan_deg_q16(i);
		logic signed [XW-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pol_s[i+1] <= pol_s[i];
				vec_s[i+1] <= vec_s[i];
				if (!vec_s[i]) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end else if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN_I;
				end
			end
		end
	end

	// gain multiply and angle rounding
	assign ux = x_s[N][XW-1] ? '0 : x_s[N][XW-2:0];
	assign zt = (ZW+1)'(z_s[N]) + (ZW+1)'(1 <<< (ANG_SH - 1));
	assign zr = zt >>> ANG_SH;

	always_comb begin
		if (zr > (ZW+1)'(DEG180_Q8)) begin
			ang = SECOND_W'(DEG180_Q8);
		end else if (zr < -((ZW+1)'(DEG180_Q8))) begin
			ang = -SECOND_W'(DEG180_Q8);
		end else begin
			ang = zr[SECOND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pol_s1 <= pol_s[N];
			vec_s1 <= vec_s[N];
			hi_s1  <= PROD_W'(ux) * PROD_W'(GAIN_HI);
			lo_s1  <= PROD_W'(ux) * PROD_W'(GAIN_LO);
			ang_s1 <= ang;
			pa_s1  <= x_s[N][FIRST_W-1:0];
			pb_s1  <= y_s[N][SECOND_W-1:0];
		end
	end

	assign prod     = (PROD_W+1)'(hi_s1) + (PROD_W+1)'(lo_s1 >> 16);
	assign rnd      = prod + ((PROD_W+1)'(1) << (MAG_SH - 1));
	assign mag      = rnd[MAG_SH +: FIRST_W];
	assign first_v  = vec_s1 ? mag : pa_s1;
	assign second_v = vec_s1 ? ang_s1 : pb_s1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= OUT_W'({second_v, first_v});
			user_q <= pol_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule
`default_nettype wire

// ===== rtl/carp_checker.sv =====
// Port-level checker for the complex add core, bound to the top level.
`default_nettype none
`include "complex_add_rect_to_polar_core_defines.svh"
module carp_checker
	import carp_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic             m_axis_tuser
);

	`CARP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result dropped or changed while stalled")
	`CARP_ASSERT_IMPL(a_mag_nonneg, clk, arst_n, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[FIRST_W-1], "negative magnitude")
	`CARP_ASSERT_IMPL(a_ang_range, clk, arst_n, m_axis_tvalid && m_axis_tuser, ($signed(m_axis_tdata[FIRST_W+SECOND_W-1:FIRST_W]) <= 17'sd46080) && ($signed(m_axis_tdata[FIRST_W+SECOND_W-1:FIRST_W]) >= -17'sd46080), "angle outside +/-180 degrees")
	`CARP_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[OUT_W-1:FIRST_W+SECOND_W] == '0, "fill bits of result not zero")

endmodule

bind complex_add_rect_to_polar_core carp_checker u_carp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking stream testbench for the complex add core with rectangular or polar result.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import carp_pkg::IN_W;
	import carp_pkg::OUT_W;

	localparam int Q_FRAC         = 8;
	localparam int ANGLE_FRAC     = 16;
	localparam int GUARD_SHIFT    = 12;
	localparam int ROT_STAGES     = 16;
	localparam longint K_HI       = 39796;   // upper half of the CORDIC gain, Q0.32
	localparam longint K_LO       = 60840;   // lower half of the CORDIC gain, Q0.32
	localparam longint HALF_TURN  = longint'(180) << Q_FRAC;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [15:0] second_im;
		logic [15:0] second_re;
		logic [15:0] first_im;
		logic [15:0] first_re;
	} operand_pair_t;

	typedef struct packed {
		logic [17:0] first_value;
		logic [16:0] second_value;
		logic        is_polar;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	operand_pair_t operand_q[$];
	conv_result_t expected_sums[$];
	logic polar_mode = 1'b1;
	int send_gap_max = 0;
	int recv_gap_max = 0;
	int hold_request = 0;
	int send_gap = 0;
	int recv_wait = 0;
	int idle_cycles = 0;
	int err_cnt = 0;
	int n_polar = 0;
	int n_rect = 0;
	int n_settings = 1;

	complex_add_rect_to_polar_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// atan(2^-i) in degrees, Q16
	function automatic longint arctan_step(input int i);
		case (i)
			0:  return 2949120;
			1:  return 1740967;
			2:  return 919879;
			3:  return 466945;
			4:  return 234379;
			5:  return 117304;
			6:  return 58666;
			7:  return 29335;
			8:  return 14668;
			9:  return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			default: return 0;
		endcase
	endfunction

	function automatic void rect_to_polar(input longint re, input longint im,
			output longint mag, output longint ang);
		longint x, y, z, dx, dy, t;
		longint unsigned ux, prod;
		z = 0;
		if (im == 0) begin
			mag = (re < 0) ? -re : re;
			ang = (re < 0) ? HALF_TURN : 0;
			return;
		end
		if (re == 0) begin
			mag = (im < 0) ? -im : im;
			ang = (im < 0) ? -(longint'(90) << Q_FRAC) : (longint'(90) << Q_FRAC);
			return;
		end
		x = re <<< GUARD_SHIFT;
		y = im <<< GUARD_SHIFT;
		// rotate by a quarter turn into the right half plane
		if (x < 0) begin
			t = x;
			if (y > 0) begin
				x = y;
				y = -t;
				z = longint'(90) << ANGLE_FRAC;
			end else begin
				x = -y;
				y = t;
				z = -(longint'(90) << ANGLE_FRAC);
			end
		end
		for (int k = 0; k < ROT_STAGES; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_step(k);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_step(k);
			end
		end
		ux = (x < 0) ? 64'd0 : longint'(x);
		prod = ux * K_HI + ((ux * K_LO) >> 16);
		mag = longint'((prod + (64'd1 << (GUARD_SHIFT + 15))) >> (GUARD_SHIFT + 16));
		z = (z + (longint'(1) << (ANGLE_FRAC - Q_FRAC - 1))) >>> (ANGLE_FRAC - Q_FRAC);
		if (z > HALF_TURN)
			z = HALF_TURN;
		if (z < -HALF_TURN)
			z = -HALF_TURN;
		ang = z;
	endfunction

	function automatic conv_result_t add_and_convert(input operand_pair_t p, input logic polar);
		conv_result_t r;
		longint re, im, mag, ang;
		re = longint'($signed(p.first_re)) + longint'($signed(p.second_re));
		im = longint'($signed(p.first_im)) + longint'($signed(p.second_im));
		if (polar) begin
			rect_to_polar(re, im, mag, ang);
			re = mag;
			im = ang;
		end
		r.first_value = re[17:0];
		r.second_value = im[16:0];
		r.is_polar = polar;
		return r;
	endfunction

	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 4))
			0:       return 16'h8000;
			1:       return 16'hFFFF;
			2:       return 16'h0000;
			3:       return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	function automatic logic [15:0] tiny_value();
		return 16'(int'($urandom_range(0, 8)) - 4);
	endfunction

	function automatic operand_pair_t random_pair();
		operand_pair_t p;
		p = operand_pair_t'({$urandom(), $urandom()});
		case ($urandom_range(0, 9))
			5: begin
				p.first_re = tiny_value();
				p.first_im = tiny_value();
				p.second_re = tiny_value();
				p.second_im = tiny_value();
			end
			// land on the real or imaginary axis
			6: p.second_im = -p.first_im;
			7: p.second_re = -p.first_re;
			8: begin
				p.first_re = corner_value();
				p.first_im = corner_value();
				p.second_re = corner_value();
				p.second_im = corner_value();
			end
			// near the negative real axis, where the angle wraps
			9: begin
				p.first_re[15] = 1'b1;
				p.second_re[15] = 1'b1;
				p.first_im = tiny_value();
				p.second_im = 16'h0000;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic queue_pair(input int fr, input int fi, input int sr, input int si);
		operand_q.push_back({16'(si), 16'(sr), 16'(fi), 16'(fr)});
	endtask

	task automatic queue_directed();
		queue_pair(0, 0, 0, 0);
		queue_pair(256, 0, 0, 0);
		queue_pair(-256, 0, 0, 0);
		queue_pair(0, 256, 0, 0);
		queue_pair(0, -256, 0, 0);
		queue_pair(100, 100, 0, 0);
		queue_pair(-100, 100, 0, 0);
		queue_pair(-100, -100, 0, 0);
		queue_pair(100, -100, 0, 0);
		queue_pair(32767, 32767, 32767, 32767);
		queue_pair(-32768, -32768, -32768, -32768);
		queue_pair(32767, -32768, 32767, -32768);
		queue_pair(-32768, 32767, -32768, 32767);
		queue_pair(-32768, 1, 0, 0);
		queue_pair(-32768, -1, 0, 0);
		queue_pair(1, 1, 0, 0);
		queue_pair(32767, -32768, -32767, 32767);
		queue_pair(-1, -1, -1, -1);
		queue_pair(12345, -23456, -32768, 32767);
		queue_pair(0, 0, -32768, 0);
		queue_pair(1, 0, -1, 0);
		queue_pair(32767, 1, 0, -1);
	endtask

	task automatic queue_random(input int count);
		for (int k = 0; k < count; k++)
			operand_q.push_back(random_pair());
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (operand_q.size() != 0 || s_axis_tvalid || expected_sums.size() != 0);
	endtask

	task automatic write_mode(input logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		polar_mode = val;
		n_settings++;
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= 40)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_result(input logic [OUT_W-1:0] data, input logic flag);
		conv_result_t want;
		logic [17:0] got_first;
		logic [16:0] got_second;
		got_first = data[17:0];
		got_second = data[34:18];
		if (expected_sums.size() == 0) begin
			report_mismatch($sformatf("result %0d/%0d with nothing pending",
				$signed(got_first), $signed(got_second)));
			return;
		end
		want = expected_sums.pop_front();
		if (want.is_polar)
			n_polar++;
		else
			n_rect++;
		if (got_first !== want.first_value)
			report_mismatch($sformatf("first_value got %0d, want %0d",
				$signed(got_first), $signed(want.first_value)));
		if (got_second !== want.second_value)
			report_mismatch($sformatf("second_value got %0d, want %0d",
				$signed(got_second), $signed(want.second_value)));
		if (flag !== want.is_polar)
			report_mismatch($sformatf("is_polar got %b, want %b", flag, want.is_polar));
	endtask

	// Driver: record each accepted transaction, then offer the next pair after its gap.
	always @(posedge clk or negedge arst_n) begin : operand_driver
		operand_pair_t cur_pair;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_sums.push_back(add_and_convert(operand_pair_t'(s_axis_tdata), polar_mode));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (operand_q.size() > 0) begin
					cur_pair = operand_q.pop_front();
					s_axis_tdata <= cur_pair;
					s_axis_tvalid <= 1'b1;
					send_gap <= $urandom_range(0, send_gap_max);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction and draw the stall before the next one.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int wait_n;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_wait <= 0;
		end else begin
			wait_n = recv_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				check_result(m_axis_tdata, m_axis_tuser);
				wait_n = $urandom_range(0, recv_gap_max);
			end
			if (hold_request > 0) begin
				wait_n = hold_request;
				hold_request = 0;
			end
			if (wait_n > 0) begin
				m_axis_tready <= 1'b0;
				recv_wait <= wait_n - 1;
			end else begin
				m_axis_tready <= 1'b1;
				recv_wait <= 0;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $time, idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : test_sequence
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// polar form from reset, light idling
		send_gap_max = 3;
		recv_gap_max = 3;
		queue_directed();
		wait_idle();

		// rectangular form, full idling on both sides
		write_mode(1'b0);
		send_gap_max = 12;
		recv_gap_max = 12;
		queue_directed();
		queue_random(300);
		wait_idle();

		// polar form; hold the output off long enough to back up the input
		write_mode(1'b1);
		send_gap_max = 0;
		recv_gap_max = 0;
		hold_request = 400;
		queue_random(200);
		wait_idle();
		send_gap_max = 6;
		recv_gap_max = 6;
		queue_random(200);
		wait_idle();

		// rectangular form, back to back
		write_mode(1'b0);
		send_gap_max = 0;
		recv_gap_max = 0;
		queue_random(250);
		wait_idle();

		// polar form, full idling
		write_mode(1'b1);
		send_gap_max = 12;
		recv_gap_max = 12;
		queue_random(400);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d polar and %0d rectangular results over %0d mode settings,",
			n_polar, n_rect, n_settings);
		$display("including axes, origin, quadrant edges, full-scale sums and output back-pressure.");
		if (err_cnt == 0 && expected_sums.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results outstanding", err_cnt, expected_sums.size());
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
